// ===== hw/rtl/sphere_triangle_subdivider_top_macros.svh =====
// Assertion macros shared by the subdivider RTL.
// Included by the top level; depends on nothing else.
`ifndef SPHERE_TRIANGLE_SUBDIVIDER_TOP_MACROS_SVH
`define SPHERE_TRIANGLE_SUBDIVIDER_TOP_MACROS_SVH

// Implication check, cycle-accurate, disabled in reset.
`define STS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication check.
`define STS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/sts_pkg.sv =====
// Package for the sphere triangle subdivider.
// Holds controller states and the controller/datapath command and status structs.
`default_nettype none
package sts_pkg;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_SUM,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_NEXT,
    ST_EMIT
  } state_t;

  localparam int unsigned NUM_RESULTS = 7;
  localparam int unsigned GUARD_BITS  = 8;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       load_corner;
    logic [1:0] corner_sel;
    logic       edge_load;
    logic [1:0] edge_sel;
    logic       sq_step;
    logic       sqrt_start;
    logic       sqrt_step;
    logic       div_start;
    logic       div_step;
    logic       store_result;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic sq_done;
    logic zero_len;
    logic sqrt_done;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sts_datapath.sv =====
// Datapath: corner store, edge sums, serial square sum, iterative root and divider.
// Depends on sts_pkg.
`default_nettype none
module sts_datapath #(
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic                 clk,
  input  sts_pkg::cmd_t        cmd,
  output sts_pkg::stat_t       stat,
  input  logic signed [15:0]   in_x,
  input  logic signed [15:0]   in_y,
  input  logic signed [15:0]   in_z,
  input  logic [15:0]          in_index,
  input  logic [23:0]          in_color,
  output logic signed [15:0]   res_pos [3][3],
  output logic [23:0]          held_color [3],
  output logic [15:0]          held_index [3]
);
  // numerator magnitude is held in NUM_BITS + 1 bits
  localparam int NUM_BITS  = COORD_FRAC_BITS + int'(sts_pkg::GUARD_BITS) + 17;
  localparam int SQ_BITS   = 36;                        // three 17-bit squares
  localparam int RAD_BITS  = SQ_BITS + 16;              // S * 2^16
  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int CNT_BITS  = $clog2(NUM_BITS + 2);

  logic signed [15:0] px [3];
  logic signed [15:0] py [3];
  logic signed [15:0] pz [3];
  logic signed [16:0] sum [3];
  logic [1:0]         edge_id;
  logic [1:0]         axis;
  logic [SQ_BITS-1:0] sq_acc;
  logic [16:0]        mag;
  logic [33:0]        mag_sq;
  logic [RAD_BITS-1:0]  rem_r;
  logic [ROOT_BITS-1:0] root;
  logic [CNT_BITS-1:0]  cnt;
  logic [CNT_BITS-1:0]  cnt_m1;
  logic [NUM_BITS:0]    dnum;
  logic [NUM_BITS+1:0]  drem;
  logic [NUM_BITS:0]    quo;
  logic                 neg;
  logic [RAD_BITS+1:0]  trial;
  logic [NUM_BITS+1:0]  dtrial;
  logic [NUM_BITS+1:0]  dden;
  logic [NUM_BITS:0]    mag_q;

  // Rounded dividend: 2 * |s| * 2^(F+G) + d, divided later by 2d.
  function automatic logic [NUM_BITS:0] dividend(logic signed [16:0] s,
                                                 logic [ROOT_BITS-1:0] d);
    logic [16:0] m;
    m = s[16] ? 17'(-s) : 17'(s);
    return ((NUM_BITS + 1)'(m) << (COORD_FRAC_BITS + int'(sts_pkg::GUARD_BITS) + 1))
           + (NUM_BITS + 1)'(d);
  endfunction

  // Hold corners.
  always_ff @(posedge clk) begin
    if (cmd.load_corner) begin
      px[cmd.corner_sel]         <= in_x;
      py[cmd.corner_sel]         <= in_y;
      pz[cmd.corner_sel]         <= in_z;
      held_index[cmd.corner_sel] <= in_index;
      held_color[cmd.corner_sel] <= in_color;
    end
  end

  // Magnitude and square of the selected component, and the root and divider trials.
  always_comb begin
    mag = sum[axis][16] ? 17'(-sum[axis]) : 17'(sum[axis]);
    mag_sq = mag * mag;
    cnt_m1 = CNT_BITS'(cnt - 1'b1);
    trial = {2'b00, rem_r} - {2'b00, (RAD_BITS'({root, 2'b01}) << (2 * cnt_m1))};
    dden = (NUM_BITS + 2)'({root, 1'b0});
    dtrial = {drem[NUM_BITS:0], dnum[NUM_BITS]} - dden;
    mag_q = quo;
  end

  // Edge sums, square accumulation, root and division sequencing.
  always_ff @(posedge clk) begin
    if (cmd.edge_load) begin
      edge_id <= cmd.edge_sel;
      axis    <= 2'd0;
      sq_acc  <= '0;
      for (int a = 0; a < 3; a++) begin
        logic [1:0] i0, i1;
        i0 = cmd.edge_sel;
        i1 = (cmd.edge_sel == 2'd2) ? 2'd0 : 2'(cmd.edge_sel + 2'd1);
        case (a)
          0: sum[a] <= 17'(px[i0]) + 17'(px[i1]);
          1: sum[a] <= 17'(py[i0]) + 17'(py[i1]);
          default: sum[a] <= 17'(pz[i0]) + 17'(pz[i1]);
        endcase
      end
    end else if (cmd.sq_step) begin
      sq_acc <= sq_acc + SQ_BITS'(mag_sq);
      axis   <= 2'(axis + 2'd1);
    end
    if (cmd.sqrt_start) begin
      rem_r <= {sq_acc, 16'd0};
      root  <= '0;
      cnt   <= CNT_BITS'(ROOT_BITS);
    end else if (cmd.sqrt_step) begin
      // One result bit per cycle (restoring square root), bit cnt-1.
      if (!trial[RAD_BITS+1]) begin
        rem_r <= trial[RAD_BITS-1:0];
        root  <= {root[ROOT_BITS-2:0], 1'b1};
      end else begin
        root  <= {root[ROOT_BITS-2:0], 1'b0};
      end
      cnt <= cnt_m1;
    end
    if (cmd.div_start) begin
      axis <= 2'd0;
      // (2*m*2^(F+8) + d) / (2d): dividend built here
      neg  <= sum[0][16];
      dnum <= dividend(sum[0], root);
      drem <= '0;
      quo  <= '0;
      cnt  <= CNT_BITS'(NUM_BITS + 1);
    end else if (cmd.div_step) begin
      if (cnt != '0) begin
        if (!dtrial[NUM_BITS+1]) begin
          drem <= dtrial;
          quo  <= {quo[NUM_BITS-1:0], 1'b1};
        end else begin
          drem <= {drem[NUM_BITS:0], dnum[NUM_BITS]};
          quo  <= {quo[NUM_BITS-1:0], 1'b0};
        end
        dnum <= {dnum[NUM_BITS-1:0], 1'b0};
        cnt  <= CNT_BITS'(cnt - 1'b1);
      end
    end
    if (cmd.store_result) begin
      if (stat.zero_len) begin
        res_pos[edge_id][axis] <= sum[axis][15:0];
      end else if (neg) begin
        res_pos[edge_id][axis] <= (mag_q > (NUM_BITS + 1)'(32768)) ? 16'sh8000
                                  : 16'(-mag_q);
      end else begin
        res_pos[edge_id][axis] <= (mag_q > (NUM_BITS + 1)'(32767)) ? 16'sh7fff
                                  : 16'(mag_q);
      end
      if (axis != 2'd2) begin
        axis <= 2'(axis + 2'd1);
        neg  <= sum[2'(axis + 2'd1)][16];
        dnum <= dividend(sum[2'(axis + 2'd1)], root);
        drem <= '0;
        quo  <= '0;
        cnt  <= CNT_BITS'(NUM_BITS + 1);
      end
    end
  end

  // Status.
  assign stat.sq_done   = (axis == 2'd3);
  assign stat.zero_len  = (sq_acc == '0);
  assign stat.sqrt_done = (cnt == '0) && !cmd.sqrt_start;
  assign stat.div_done  = (cnt == '0);
endmodule
`default_nettype wire

// ===== hw/rtl/sts_controller.sv =====
// Controller state machine: corner count, edge sequencing and result emission.
// Depends on sts_pkg.
`default_nettype none
module sts_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           out_free,
  input  sts_pkg::stat_t stat,
  output sts_pkg::cmd_t  cmd,
  output logic           in_rdy,
  output logic           emit,
  output logic [2:0]     emit_sel
);
  sts_pkg::state_t state, state_next;
  logic [1:0] corner, corner_next;
  logic [1:0] edge_n, edge_n_next;
  logic [1:0] ax, ax_next;
  logic [2:0] res, res_next;

  // Hold state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sts_pkg::ST_COLLECT;
      corner <= '0;
      edge_n <= '0;
      ax     <= '0;
      res    <= '0;
    end else begin
      state  <= state_next;
      corner <= corner_next;
      edge_n <= edge_n_next;
      ax     <= ax_next;
      res    <= res_next;
    end
  end

  // Advance sequence.
  always_comb begin
    state_next  = state;
    corner_next = corner;
    edge_n_next = edge_n;
    ax_next     = ax;
    res_next    = res;
    cmd         = '0;
    in_rdy      = 1'b0;
    emit        = 1'b0;
    emit_sel    = res;
    unique case (state)
      sts_pkg::ST_COLLECT: begin
        in_rdy = 1'b1;
        cmd.corner_sel = corner;
        if (in_fire) begin
          cmd.load_corner = 1'b1;
          if (corner == 2'd2) begin
            corner_next = '0;
            edge_n_next = '0;
            state_next  = sts_pkg::ST_SUM;
          end else begin
            corner_next = 2'(corner + 2'd1);
          end
        end
      end
      sts_pkg::ST_SUM: begin
        cmd.edge_load = 1'b1;
        cmd.edge_sel  = edge_n;
        state_next    = sts_pkg::ST_SQ;
      end
      sts_pkg::ST_SQ: begin
        if (stat.sq_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = sts_pkg::ST_SQRT;
        end else begin
          cmd.sq_step = 1'b1;
        end
      end
      sts_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_done) begin
          cmd.sqrt_step = 1'b0;
          cmd.div_start = 1'b1;
          ax_next       = '0;
          state_next    = sts_pkg::ST_DIV;
        end
      end
      sts_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          cmd.store_result = 1'b1;
          if (ax == 2'd2) begin
            state_next = sts_pkg::ST_NEXT;
          end else begin
            ax_next = 2'(ax + 2'd1);
          end
        end
      end
      sts_pkg::ST_NEXT: begin
        if (edge_n == 2'd2) begin
          res_next   = '0;
          state_next = sts_pkg::ST_EMIT;
        end else begin
          edge_n_next = 2'(edge_n + 2'd1);
          state_next  = sts_pkg::ST_SUM;
        end
      end
      sts_pkg::ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (res == 3'(sts_pkg::NUM_RESULTS - 1)) begin
            state_next = sts_pkg::ST_COLLECT;
          end else begin
            res_next = 3'(res + 3'd1);
          end
        end
      end
      default: state_next = sts_pkg::ST_COLLECT;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sphere_triangle_subdivider_top.sv =====
// Top level of the sphere triangle subdivider: ports, register, output word.
// Depends on sts_pkg, sts_controller, sts_datapath and the macros header.
//
// channel  | dir | word
// s_axis   | in  | one triangle corner
// m_axis   | out | new vertex or sub-triangle
// apb      | in  | base_vertex_count at address 0
//
// Corners are taken while the controller collects. After corner 3 each edge
// goes through the sum, squaring, root and a division per axis, then a
// step to advance; the pace is set by the shared bit-serial root and divider,
// and no new corner is taken until the last result of a triangle is emitted.
// Seven results then follow one per cycle through an output register that
// holds under stall. Reset restores base_vertex_count to 12 and clears the
// corner count.
`default_nettype none
`include "sphere_triangle_subdivider_top_macros.svh"
module sphere_triangle_subdivider_top #(
  parameter int INDEX_BITS      = 16,
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // corner_x, corner_y, corner_z, corner_index, corner_color
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, vertex_color, vertex_index, tri_a, tri_b, tri_c
  output logic [135:0] m_axis_tdata,
  // is_triangle
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam logic [1:0] ADDR_BASE = 2'd0;

  sts_pkg::cmd_t  cmd;
  sts_pkg::stat_t stat;
  logic                   in_fire, out_free, emit;
  logic [2:0]             emit_sel;
  logic [15:0]            base_count;
  logic [INDEX_BITS-1:0]  next_free;
  logic signed [15:0]     res_pos [3][3];
  logic [23:0]            hcol [3];
  logic [15:0]            hidx [3];
  logic [INDEX_BITS-1:0]  n0, n1, n2;
  logic [15:0]            m0, m1, m2;
  logic [135:0]           word;

  assign pready   = 1'b1;
  assign prdata   = {16'd0, base_count};
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Register write and fresh index counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_count <= 16'd12;
      next_free  <= INDEX_BITS'(16'd12);
    end else if (psel && penable && pwrite && paddr == ADDR_BASE) begin
      base_count <= pwdata[15:0];
      next_free  <= INDEX_BITS'(pwdata[15:0]);
    end else if (emit && emit_sel == 3'(sts_pkg::NUM_RESULTS - 1)) begin
      next_free <= INDEX_BITS'(next_free + INDEX_BITS'(3));
    end
  end

  sts_controller u_ctrl (
    .clk, .rst, .in_fire, .out_free, .stat, .cmd,
    .in_rdy(s_axis_tready), .emit, .emit_sel
  );

  sts_datapath #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
    .clk, .cmd, .stat,
    .in_x(s_axis_tdata[15:0]), .in_y(s_axis_tdata[31:16]), .in_z(s_axis_tdata[47:32]),
    .in_index(s_axis_tdata[63:48]), .in_color(s_axis_tdata[87:64]),
    .res_pos, .held_color(hcol), .held_index(hidx)
  );

  assign n0 = next_free;
  assign n1 = INDEX_BITS'(next_free + INDEX_BITS'(1));
  assign n2 = INDEX_BITS'(next_free + INDEX_BITS'(2));
  assign m0 = 16'(n0);
  assign m1 = 16'(n1);
  assign m2 = 16'(n2);

  // Select result word.
  always_comb begin
    word = '0;
    case (emit_sel)
      3'd0, 3'd1, 3'd2: begin
        word[15:0]   = res_pos[emit_sel[1:0]][0];
        word[31:16]  = res_pos[emit_sel[1:0]][1];
        word[47:32]  = res_pos[emit_sel[1:0]][2];
        word[71:48]  = hcol[emit_sel[1:0]];
        word[87:72]  = (emit_sel == 3'd0) ? m0 : (emit_sel == 3'd1) ? m1 : m2;
      end
      3'd3: word[135:88] = {m2, m0, hidx[0]};
      3'd4: word[135:88] = {m0, m1, hidx[1]};
      3'd5: word[135:88] = {m1, m2, hidx[2]};
      default: word[135:88] = {m2, m1, m0};
    endcase
  end

  // Output register; hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= word;
      m_axis_tuser <= (emit_sel > 3'd2);
      m_axis_tlast <= (emit_sel == 3'(sts_pkg::NUM_RESULTS - 1));
    end
  end

  `STS_ASSERT_IMP(a_no_in_while_out, m_axis_tvalid && !m_axis_tready && s_axis_tready, !emit)
  `STS_ASSERT_IMP(a_emit_free, emit, out_free)
  `STS_ASSERT_NXT(a_emit_valid, emit, m_axis_tvalid)
endmodule
`default_nettype wire
